// File: rtl/stq_pkg.sv
package stq_pkg;

  // Storage geometry
  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  // Port field widths
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 6;
  localparam int OUT_W   = 88;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ENQ  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEQ  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_XFER = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Advance a queue index, wrapping at the depth
  function automatic logic [AW-1:0] next_index(input logic [AW-1:0] i);
    next_index = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

endpackage

// File: rtl/stq_ram.sv
module stq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/stack_to_queue_transfer_core.sv
// Channel   Direction  Handshake               Payload
// in_*      input      in_tvalid / in_tready   tuser: req_type; tdata: data_value
// out_*     output     out_tvalid / out_tready tuser: status; tdata: front, counts, top, moved
//
// Push, pop, enqueue, dequeue and unknown codes: the accept cycle updates the
// fill levels, writes the memory and reads the new top and front; S_RESP then
// loads the output register. A transfer of n words alternates S_XFER_RD and
// S_XFER_WR: each word is a registered stack read followed by a queue write.
// Synchronous active-low reset empties both structures; memory contents stay.
// A result held in the output register does not block acceptance; a further
// result waits in the final state until the register is free.
module stack_to_queue_transfer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_value
  input  logic [7:0]  in_tuser,   // [2:0] req_type, rest unused
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [31:0] queue_front, [37:32] queue_count,
                                  // [69:38] stack_top, [75:70] stack_count,
                                  // [81:76] moved_count, [87:82] zero
  output logic [7:0]  out_tuser   // [1:0] status, rest zero
);

  localparam int AW = stq_pkg::AW;
  localparam int CW = stq_pkg::CW;
  localparam int DW = stq_pkg::DATA_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER_RD,
    S_XFER_WR,
    S_RESP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 sfill_r, sfill_nxt;
  logic [CW-1:0]                 qfill_r, qfill_nxt;
  logic [AW-1:0]                 rd_r, rd_nxt;
  logic [AW-1:0]                 wr_r, wr_nxt;
  logic [CW-1:0]                 moved_r, moved_nxt;
  logic [stq_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic                          stk_fwd_r, stk_fwd_nxt;
  logic                          que_fwd_r, que_fwd_nxt;
  logic [DW-1:0]                 word_r, word_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [stq_pkg::OUT_W-1:0]     out_data_r, out_data_nxt;
  logic [stq_pkg::STAT_W-1:0]    out_stat_r, out_stat_nxt;

  logic                          s_we, s_re, q_we, q_re;
  logic [AW-1:0]                 s_waddr, s_raddr, q_waddr, q_raddr;
  logic [DW-1:0]                 s_wdata, q_wdata, s_rdata, q_rdata;
  logic [DW-1:0]                 word_in, top_w, front_w;
  logic [stq_pkg::REQ_W-1:0]     req_in;

  assign req_in  = in_tuser[stq_pkg::REQ_W-1:0];
  assign word_in = DW'(in_tdata);

  // Stack and queue storage
  stq_ram #(.WIDTH(DW), .DEPTH(stq_pkg::DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  stq_ram #(.WIDTH(DW), .DEPTH(stq_pkg::DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Pick top and front, forwarding a word written in the same cycle as its read
  assign top_w   = (sfill_r != '0) ? (stk_fwd_r ? word_r : s_rdata) : '0;
  assign front_w = (qfill_r != '0) ? (que_fwd_r ? word_r : q_rdata) : '0;

  // Next-state logic and memory control
  always_comb begin
    state_nxt     = state_r;
    sfill_nxt     = sfill_r;
    qfill_nxt     = qfill_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    moved_nxt     = moved_r;
    status_nxt    = status_r;
    stk_fwd_nxt   = stk_fwd_r;
    que_fwd_nxt   = que_fwd_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;

    s_we    = 1'b0;
    s_waddr = sfill_r[AW-1:0];
    s_wdata = word_in;
    s_re    = 1'b0;
    s_raddr = AW'(sfill_r - CW'(1));
    q_we    = 1'b0;
    q_waddr = wr_r;
    q_wdata = s_rdata;
    q_re    = 1'b0;
    q_raddr = rd_r;

    // Drop the output beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          word_nxt    = word_in;
          stk_fwd_nxt = 1'b0;
          que_fwd_nxt = 1'b0;
          status_nxt  = stq_pkg::ST_OK;
          moved_nxt   = '0;
          state_nxt   = S_RESP;
          case (req_in)
            stq_pkg::REQ_PUSH: begin
              if (sfill_r == CW'(stq_pkg::DEPTH)) begin
                status_nxt = stq_pkg::ST_FULL;
              end else begin
                s_we        = 1'b1;
                sfill_nxt   = sfill_r + CW'(1);
                stk_fwd_nxt = 1'b1;
              end
            end
            stq_pkg::REQ_POP: begin
              if (sfill_r == '0) begin
                status_nxt = stq_pkg::ST_EMPTY;
              end else begin
                sfill_nxt = sfill_r - CW'(1);
              end
            end
            stq_pkg::REQ_ENQ: begin
              if (qfill_r == CW'(stq_pkg::DEPTH)) begin
                status_nxt = stq_pkg::ST_FULL;
              end else begin
                q_we        = 1'b1;
                q_wdata     = word_in;
                wr_nxt      = stq_pkg::next_index(wr_r);
                qfill_nxt   = qfill_r + CW'(1);
                que_fwd_nxt = (qfill_r == '0);
              end
            end
            stq_pkg::REQ_DEQ: begin
              if (qfill_r == '0) begin
                status_nxt = stq_pkg::ST_EMPTY;
              end else begin
                rd_nxt    = stq_pkg::next_index(rd_r);
                qfill_nxt = qfill_r - CW'(1);
              end
            end
            stq_pkg::REQ_XFER: begin
              state_nxt = S_XFER_RD;
            end
            default: begin
            end
          endcase
          // Read the new top and front
          s_re    = 1'b1;
          s_raddr = AW'(sfill_nxt - CW'(1));
          q_re    = 1'b1;
          q_raddr = rd_nxt;
        end
      end

      S_XFER_RD: begin
        // Read the stack top: next word to move, or the final top
        s_re = 1'b1;
        if (sfill_r != '0 && qfill_r != CW'(stq_pkg::DEPTH)) begin
          state_nxt = S_XFER_WR;
        end else begin
          q_re        = 1'b1;
          stk_fwd_nxt = 1'b0;
          que_fwd_nxt = 1'b0;
          status_nxt  = (sfill_r != '0) ? stq_pkg::ST_FULL : stq_pkg::ST_OK;
          state_nxt   = S_RESP;
        end
      end

      S_XFER_WR: begin
        // Move one word from stack to queue
        q_we      = 1'b1;
        sfill_nxt = sfill_r - CW'(1);
        qfill_nxt = qfill_r + CW'(1);
        wr_nxt    = stq_pkg::next_index(wr_r);
        moved_nxt = moved_r + CW'(1);
        state_nxt = S_XFER_RD;
      end

      S_RESP: begin
        // Load the output register when it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = status_r;
          out_data_nxt  = {6'b0,
                           stq_pkg::COUNT_W'(moved_r),
                           stq_pkg::COUNT_W'(sfill_r),
                           stq_pkg::WORD_W'(top_w),
                           stq_pkg::COUNT_W'(qfill_r),
                           stq_pkg::WORD_W'(front_w)};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sfill_r     <= '0;
      qfill_r     <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sfill_r     <= sfill_nxt;
      qfill_r     <= qfill_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    moved_r    <= moved_nxt;
    status_r   <= status_nxt;
    stk_fwd_r  <= stk_fwd_nxt;
    que_fwd_r  <= que_fwd_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {6'b0, out_stat_r};

endmodule

// File: rtl/stq_checker.sv
module stq_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [7:0]  out_tuser
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Drop ready in the cycle after each request beat
  a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted in two consecutive cycles");

  // Keep both fill levels within the depth
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:32] <= 6'(stq_pkg::DEPTH) &&
                   out_tdata[75:70] <= 6'(stq_pkg::DEPTH))
    else $error("fill level beyond depth");

  // Show zero for an empty structure
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[75:70] == 6'd0 || out_tdata[37:32] == 6'd0) |->
      (out_tdata[75:70] != 6'd0 || out_tdata[69:38] == 32'd0) &&
      (out_tdata[37:32] != 6'd0 || out_tdata[31:0] == 32'd0))
    else $error("empty structure shows a non-zero word");

  // Move no more words than the queue now holds; keep status in range
  a_moved: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[81:76] <= out_tdata[37:32] &&
                   out_tuser[1:0] != 2'd3)
    else $error("moved count or status out of range");

endmodule

bind stack_to_queue_transfer_core stq_assertions u_stq_assertions (.*);
